@@ rtl/kvbrf_pkg.sv @@
// Types, constants and codes shared by the binary request framer.
`default_nettype none

package kvbrf_pkg;

	localparam int HEADER_BYTES = 24;
	localparam int HDR_CNT_W    = 5;

	localparam logic [7:0] REQ_MAGIC  = 8'h80;
	localparam logic [7:0] EXTRAS_SET = 8'd8;
	localparam logic [7:0] OP_GET     = 8'h00;
	localparam logic [7:0] OP_SET     = 8'h01;
	localparam logic [7:0] OP_DELETE  = 8'h04;

	localparam logic [15:0] MAX_KEY_RESET = 16'd250;
	localparam logic [31:0] MAX_VAL_RESET = 32'd1048576;

	typedef enum logic [0:0] {
		CFG_MAX_KEY = 1'b0,
		CFG_MAX_VAL = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_BODY,
		PH_CLOSED
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVAL   = 3'd1,
		ST_TOOBIG  = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_MAGIC   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [15:0] key_length;
		logic [7:0]  extras_length;
		logic [31:0] body_length;
	} hdr_t;

	typedef struct packed {
		logic [15:0] max_key_length;
		logic [31:0] max_value_length;
	} limits_t;

	typedef struct packed {
		status_t     status;
		logic        close_session;
		logic [7:0]  opcode;
		logic [15:0] key_length;
		logic [7:0]  extras_length;
		logic [31:0] body_length;
		logic [31:0] opaque_tag;
		logic [63:0] cas_value;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/kvbrf_check.sv @@
// Header validation: length rules and configured limits per opcode.
`default_nettype none

module kvbrf_check (
	input  kvbrf_pkg::hdr_t    hdr,
	input  kvbrf_pkg::limits_t limits,
	output kvbrf_pkg::status_t status
);
	import kvbrf_pkg::*;

	logic [32:0] key_plus_extras;
	logic [33:0] value_limit;
	logic        set_inval;
	logic        set_toobig;
	logic        gd_inval;

	assign key_plus_extras = {17'd0, hdr.key_length} + {25'd0, EXTRAS_SET};
	assign value_limit     = {2'd0, limits.max_value_length} + {1'b0, key_plus_extras};

	assign set_inval = (hdr.extras_length != EXTRAS_SET) || (hdr.key_length == 16'd0) ||
		({1'b0, hdr.body_length} < key_plus_extras) ||
		(hdr.key_length > limits.max_key_length);
	assign set_toobig = {2'd0, hdr.body_length} > value_limit;
	assign gd_inval = (hdr.extras_length != 8'd0) || (hdr.key_length == 16'd0) ||
		(hdr.body_length != {16'd0, hdr.key_length});

	always_comb begin
		case (hdr.opcode)
			OP_SET: begin
				if (set_inval)
					status = ST_INVAL;
				else if (set_toobig)
					status = ST_TOOBIG;
				else
					status = ST_OK;
			end
			OP_GET, OP_DELETE: begin
				status = gd_inval ? ST_INVAL : ST_OK;
			end
			default: begin
				status = ST_UNKNOWN;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/kv_binary_request_framer_core.sv @@
// Binary key-value request framer: header parse, validation, body count.
//
// Usage:
//   s_axis carries the request stream, one byte per item in tdata.
//   m_axis carries result items: tuser holds status and close_session,
//   tdata holds the header fields of the request.
//   cfg writes max_key_length (index 0) and max_value_length (index 1);
//   cfg_ready is always high. Write only while the framer is idle.
// Throughput: one byte per cycle while s_axis_tready is high. A result is
//   registered at the byte that causes it (last header or last body byte).
// Results: status 0 at the last body byte of a valid request (or its last
//   header byte for an empty body); status 1/2 closes the stream; status 3
//   reports an unknown opcode and skips its body; a bad magic byte gives
//   status 4 and closes the stream. A closed stream drops every byte.
// Stalls: results go to a two-entry output buffer. Bytes keep flowing while
//   one result waits; s_axis_tready drops only when both entries are full.
// Reset: arst_n clears the parser to await magic, empties the output
//   buffer and restores the default limits.
`default_nettype none

module kv_binary_request_framer_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // [7:0] opcode, [23:8] key_length,
	                                    // [31:24] extras_length, [63:32] body_length,
	                                    // [95:64] opaque_tag, [159:96] cas_value
	output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] close_session
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [0:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import kvbrf_pkg::*;

	phase_t              phase_q, phase_nxt;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [7:0]          opcode_q;
	logic [15:0]         key_len_q;
	logic [7:0]          extras_len_q;
	logic [31:0]         body_len_q;
	logic [31:0]         opaque_q;
	logic [63:0]         cas_q;
	logic [31:0]         body_rem_q;
	limits_t             limits_q;

	logic    in_acc;
	logic    hdr_last;
	logic    body_last;
	status_t chk_status;
	hdr_t    hdr;
	logic    res_push;
	result_t res;

	result_t out_q, skid_q;
	logic    out_vld_q, skid_vld_q;
	logic    out_pop;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_vld_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign hdr_last      = (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1));
	assign body_last     = (body_rem_q <= 32'd1);

	assign hdr = '{opcode: opcode_q, key_length: key_len_q,
		extras_length: extras_len_q, body_length: body_len_q};

	kvbrf_check u_check (
		.hdr    (hdr),
		.limits (limits_q),
		.status (chk_status)
	);

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_IDLE: begin
				phase_nxt = (s_axis_tdata == REQ_MAGIC) ? PH_HEADER : PH_CLOSED;
			end
			PH_HEADER: begin
				if (hdr_last) begin
					if (chk_status == ST_INVAL || chk_status == ST_TOOBIG)
						phase_nxt = PH_CLOSED;
					else if (body_len_q != 32'd0)
						phase_nxt = PH_BODY;
					else
						phase_nxt = PH_IDLE;
				end
			end
			PH_BODY: begin
				if (body_last)
					phase_nxt = PH_IDLE;
			end
			default: begin
				phase_nxt = PH_CLOSED;
			end
		endcase
	end

	// result item
	always_comb begin
		res_push          = 1'b0;
		res.status        = ST_OK;
		res.close_session = 1'b0;
		res.opcode        = opcode_q;
		res.key_length    = key_len_q;
		res.extras_length = extras_len_q;
		res.body_length   = body_len_q;
		res.opaque_tag    = opaque_q;
		res.cas_value     = cas_q;
		case (phase_q)
			PH_IDLE: begin
				if (s_axis_tdata != REQ_MAGIC) begin
					res_push          = 1'b1;
					res.status        = ST_MAGIC;
					res.close_session = 1'b1;
					res.opcode        = '0;
					res.key_length    = '0;
					res.extras_length = '0;
					res.body_length   = '0;
					res.opaque_tag    = '0;
					res.cas_value     = '0;
				end
			end
			PH_HEADER: begin
				res.cas_value = {cas_q[55:0], s_axis_tdata};
				if (hdr_last) begin
					res.status = chk_status;
					if (chk_status == ST_INVAL || chk_status == ST_TOOBIG) begin
						res_push          = 1'b1;
						res.close_session = 1'b1;
					end else if (chk_status == ST_UNKNOWN || body_len_q == 32'd0) begin
						res_push = 1'b1;
					end
				end
			end
			PH_BODY: begin
				res_push = body_last &&
					(opcode_q == OP_GET || opcode_q == OP_SET || opcode_q == OP_DELETE);
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			hdr_cnt_q  <= '0;
			body_rem_q <= '0;
		end else if (in_acc) begin
			phase_q <= phase_nxt;
			case (phase_q)
				PH_IDLE: begin
					hdr_cnt_q <= HDR_CNT_W'(1);
				end
				PH_HEADER: begin
					hdr_cnt_q <= hdr_last ? '0 : hdr_cnt_q + HDR_CNT_W'(1);
					if (hdr_last)
						body_rem_q <= body_len_q;
				end
				PH_BODY: begin
					if (body_rem_q != 32'd0)
						body_rem_q <= body_rem_q - 32'd1;
				end
				default: begin
					hdr_cnt_q <= hdr_cnt_q;
				end
			endcase
		end
	end

	// header field capture, big-endian
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q     <= '0;
			key_len_q    <= '0;
			extras_len_q <= '0;
			body_len_q   <= '0;
			opaque_q     <= '0;
			cas_q        <= '0;
		end else if (in_acc) begin
			if (phase_q == PH_IDLE && s_axis_tdata == REQ_MAGIC) begin
				opcode_q     <= '0;
				key_len_q    <= '0;
				extras_len_q <= '0;
				body_len_q   <= '0;
				opaque_q     <= '0;
				cas_q        <= '0;
			end else if (phase_q == PH_HEADER) begin
				case (hdr_cnt_q) inside
					5'd1:           opcode_q     <= s_axis_tdata;
					[5'd2:5'd3]:    key_len_q    <= {key_len_q[7:0], s_axis_tdata};
					5'd4:           extras_len_q <= s_axis_tdata;
					[5'd8:5'd11]:   body_len_q   <= {body_len_q[23:0], s_axis_tdata};
					[5'd12:5'd15]:  opaque_q     <= {opaque_q[23:0], s_axis_tdata};
					[5'd16:5'd23]:  cas_q        <= {cas_q[55:0], s_axis_tdata};
					default:        opcode_q     <= opcode_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_key_length   <= MAX_KEY_RESET;
			limits_q.max_value_length <= MAX_VAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAX_KEY: limits_q.max_key_length   <= cfg_data[15:0];
				CFG_MAX_VAL: limits_q.max_value_length <= cfg_data;
				default:     limits_q <= limits_q;
			endcase
		end
	end

	// two-entry output buffer
	assign out_pop = out_vld_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= in_acc && res_push;
			end
		end else if (in_acc && res_push) begin
			if (!out_vld_q)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_pop) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (in_acc && res_push) begin
			if (!out_vld_q)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = {out_q.close_session, out_q.status};
	assign m_axis_tdata  = {out_q.cas_value, out_q.opaque_tag, out_q.body_length,
		out_q.extras_length, out_q.key_length, out_q.opcode};

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held without a head entry");

	a_closed_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("closed stream reopened without reset");

	a_close_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[3]) |->
		(m_axis_tuser[2:0] == ST_INVAL || m_axis_tuser[2:0] == ST_TOOBIG ||
		 m_axis_tuser[2:0] == ST_MAGIC))
		else $error("close_session with a non-fatal status");

	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> body_rem_q != 32'd0)
		else $error("body phase with no bytes left");

endmodule

`default_nettype wire
